### hw/rtl/loog_pkg.sv
// Shared types, grid geometry and the logistic threshold table of the occupancy grid.
// No dependencies; used by loog_occ and log_odds_occupancy_grid.
package loog_pkg;

  localparam int GridCols = 64;
  localparam int GridRows = 64;
  localparam int FracBits = 8;
  localparam int Cells    = GridCols * GridRows;
  localparam int AddrW    = $clog2(Cells);
  localparam int RowW     = (GridRows > 2) ? $clog2(GridRows) : 1;
  localparam int ColW     = (GridCols > 2) ? $clog2(GridCols) : 1;
  localparam int RcMaxW   = (RowW > ColW) ? RowW : ColW;
  localparam int PosW     = ((RcMaxW > 8) ? RcMaxW : 8) + 2;

  localparam int LoW   = 16;
  localparam int OccW  = 8;
  localparam int CellW = LoW + OccW;
  localparam int LimW  = 15;

  localparam int ThrCount = 50;
  localparam int ThrW     = 19;
  localparam int SearchW  = $clog2(ThrCount + 1);
  localparam int StepW    = $clog2(SearchW);
  localparam int MagW     = LoW + 1 + 16 - FracBits;

  localparam logic signed [OccW-1:0] OccUnknown = -8'sd1;
  localparam logic signed [OccW-1:0] OccEmpty   = 8'sd0;
  localparam logic signed [OccW-1:0] OccFull    = 8'sd100;

  localparam logic signed [LoW-1:0]  HitIncRst   = 16'sd562;
  localparam logic signed [LoW-1:0]  MissIncRst  = -16'sd217;
  localparam logic        [LimW-1:0] LoLimitRst  = 15'd25600;
  localparam logic        [LimW-1:0] BeliefRst   = 15'd5120;

  // ln((100+j)/(100-j)) in Q16 for odd j = 1..99
  localparam logic [ThrW-1:0] LogitThr [ThrCount] = '{
    19'd1311,   19'd3933,   19'd6559,   19'd9190,   19'd11828,
    19'd14476,  19'd17136,  19'd19810,  19'd22501,  19'd25210,
    19'd27941,  19'd30696,  19'd33477,  19'd36289,  19'd39134,
    19'd42015,  19'd44935,  19'd47899,  19'd50911,  19'd53975,
    19'd57096,  19'd60280,  19'd63531,  19'd66856,  19'd70263,
    19'd73758,  19'd77352,  19'd81052,  19'd84872,  19'd88823,
    19'd92920,  19'd97179,  19'd101620, 19'd106266, 19'd111143,
    19'd116285, 19'd121730, 19'd127527, 19'd133736, 19'd140435,
    19'd147722, 19'd155731, 19'd164646, 19'd174729, 19'd186375,
    19'd200216, 19'd217368, 19'd240095, 19'd274241, 19'd346902
  };

  typedef enum logic [1:0] {
    ActUpdate = 2'd0,
    ActShift  = 2'd1,
    ActRead   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CfgHitInc      = 2'd0,
    CfgMissInc     = 2'd1,
    CfgLogOddsLim  = 2'd2,
    CfgBeliefLim   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                  valid;
    logic signed [LoW-1:0] log_odds;
  } occ_req_t;

  typedef struct packed {
    logic                   valid;
    logic signed [OccW-1:0] occ;
  } occ_rsp_t;

endpackage

### hw/rtl/loog_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module loog_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/loog_occ.sv
// Occupancy from log-odds: belief-limit check, then a bit-per-cycle search of the
// logistic threshold table through one shared comparator. Depends on loog_pkg.
module loog_occ
  import loog_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  occ_req_t        req_i,
  input  logic [LimW-1:0] belief_limit_i,
  output occ_rsp_t        rsp_o
);

  logic                 busy_q, busy_d;
  logic                 neg_q, neg_d;
  logic [MagW-1:0]      mag_q, mag_d;
  logic [SearchW-1:0]   n_q, n_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 rsp_v_q, rsp_v_d;
  logic signed [OccW-1:0] occ_q, occ_d;

  logic signed [LoW:0]  lo_ext;
  logic signed [LoW:0]  bel_ext;
  logic [LoW:0]         lo_abs;
  logic [SearchW:0]     probe;
  logic [SearchW:0]     probe_idx;
  logic                 probe_in;
  logic [ThrW-1:0]      thr;
  logic [MagW-1:0]      thr_ext;
  logic                 take;

  assign lo_ext  = {req_i.log_odds[LoW-1], req_i.log_odds};
  assign bel_ext = $signed({2'b00, belief_limit_i});
  assign lo_abs  = lo_ext[LoW] ? 17'(-lo_ext) : 17'(lo_ext);

  assign probe     = {1'b0, n_q} + ((SearchW + 1)'(1) << step_q);
  assign probe_idx = probe - (SearchW + 1)'(1);
  assign probe_in  = (probe <= (SearchW + 1)'(ThrCount));
  assign thr       = LogitThr[probe_in ? probe_idx[SearchW-1:0] : '0];
  assign thr_ext   = MagW'(thr);
  assign take      = probe_in && (neg_q ? (thr_ext < mag_q) : (thr_ext <= mag_q));

  always_comb begin
    busy_d  = busy_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    n_d     = n_q;
    step_d  = step_q;
    rsp_v_d = 1'b0;
    occ_d   = occ_q;
    if (busy_q) begin
      n_d = take ? probe[SearchW-1:0] : n_q;
      if (step_q == '0) begin
        busy_d  = 1'b0;
        rsp_v_d = 1'b1;
        occ_d   = neg_q ? $signed(OccW'(ThrCount) - OccW'(n_d))
                        : $signed(OccW'(ThrCount) + OccW'(n_d));
      end else begin
        step_d = step_q - StepW'(1);
      end
    end else if (req_i.valid) begin
      if (lo_ext < -bel_ext) begin
        rsp_v_d = 1'b1;
        occ_d   = OccEmpty;
      end else if (lo_ext > bel_ext) begin
        rsp_v_d = 1'b1;
        occ_d   = OccFull;
      end else begin
        busy_d = 1'b1;
        neg_d  = lo_ext[LoW];
        mag_d  = MagW'(lo_abs) << (16 - FracBits);
        n_d    = '0;
        step_d = StepW'(SearchW - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rsp_v_q <= 1'b0;
      step_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      rsp_v_q <= rsp_v_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    n_q   <= n_d;
    occ_q <= occ_d;
  end

  assign rsp_o.valid = rsp_v_q;
  assign rsp_o.occ   = occ_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> !busy_q && !rsp_v_q)
    else $error("occupancy request while search is running");
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (occ_q >= OccEmpty) && (occ_q <= OccFull))
    else $error("occupancy out of range");
`endif

endmodule

### hw/rtl/log_odds_occupancy_grid.sv
// Log-odds occupancy grid: sequencer, config registers, cell RAM and output register.
// Depends on loog_pkg, loog_ram and loog_occ.
//
// After reset the block sweeps the cell RAM once, one cell per cycle, with
// s_axis_tready low; config writes are taken throughout. A read goes through one
// registered RAM read and then the output register. An update does the RAM read,
// add and clamp, then the belief-limit check and, within the limit, the occupancy
// search, which walks the 50-entry logistic table one bit per cycle on a single
// comparator. A shift with a nonzero displacement moves one cell per cycle through
// the RAM's read and write ports, in place, scanning up or down so no source is
// overwritten before it is read. A zero shift or an out-of-grid index is answered in
// the cycle after it is taken. One request is handled at a time.
module log_odds_occupancy_grid
  import loog_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] cell_index, [12] hit, [20:13] shift_dx, [28:21] shift_dy, [31:29] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] cell_occupancy, [23:8] cell_log_odds
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [5:0] {
    StClear  = 6'b000001,
    StIdle   = 6'b000010,
    StData   = 6'b000100,
    StOcc    = 6'b001000,
    StShift  = 6'b010000,
    StShTail = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [LoW-1:0] hit_inc_q, miss_inc_q;
  logic [LimW-1:0]       lo_limit_q, belief_q;

  logic [AddrW-1:0] clr_q, clr_d;
  action_e          act_q, act_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             hit_q, hit_d;
  logic signed [7:0] dx_q, dx_d, dy_q, dy_d;
  logic             asc_q, asc_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             pend_v_q, pend_v_d;
  logic             pend_in_q, pend_in_d;
  logic [AddrW-1:0] pend_addr_q, pend_addr_d;
  logic signed [LoW-1:0] lo_new_q, lo_new_d;

  logic                   out_v_q, out_v_d;
  logic signed [OccW-1:0] out_occ_q, out_occ_d;
  logic signed [LoW-1:0]  out_lo_q, out_lo_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  occ_req_t occ_req;
  occ_rsp_t occ_rsp;

  logic             accept;
  action_e          in_act;
  logic [11:0]      in_idx;
  logic signed [7:0] in_dx, in_dy;
  logic             in_grid;

  logic signed [LoW-1:0]  rd_lo;
  logic signed [OccW-1:0] rd_occ;
  logic signed [LoW:0]    sum, lim;

  logic signed [PosW-1:0] src_r, src_c;
  logic             src_in;
  logic [AddrW-1:0] src_addr, dst_addr;
  logic             sh_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_inc_q  <= HitIncRst;
      miss_inc_q <= MissIncRst;
      lo_limit_q <= LoLimitRst;
      belief_q   <= BeliefRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgHitInc:     hit_inc_q  <= $signed(cfg_data_i);
        CfgMissInc:    miss_inc_q <= $signed(cfg_data_i);
        CfgLogOddsLim: lo_limit_q <= cfg_data_i[LimW-1:0];
        CfgBeliefLim:  belief_q   <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle) && (!out_v_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_act        = action_e'(s_axis_tuser);
  assign in_idx        = s_axis_tdata[11:0];
  assign in_dx         = $signed(s_axis_tdata[20:13]);
  assign in_dy         = $signed(s_axis_tdata[28:21]);
  assign in_grid       = int'(in_idx) < Cells;

  assign rd_lo  = $signed(ram_rdata[LoW-1:0]);
  assign rd_occ = $signed(ram_rdata[CellW-1:LoW]);
  assign sum    = {rd_lo[LoW-1], rd_lo}
                + (hit_q ? {hit_inc_q[LoW-1], hit_inc_q} : {miss_inc_q[LoW-1], miss_inc_q});
  assign lim    = $signed({2'b00, lo_limit_q});

  assign src_r    = PosW'($signed({1'b0, row_q})) + PosW'(dy_q);
  assign src_c    = PosW'($signed({1'b0, col_q})) + PosW'(dx_q);
  assign src_in   = (src_r >= 0) && (src_r < PosW'(GridRows))
                 && (src_c >= 0) && (src_c < PosW'(GridCols));
  assign src_addr = AddrW'(src_r[RowW-1:0]) * AddrW'(GridCols) + AddrW'(src_c[ColW-1:0]);
  assign dst_addr = AddrW'(row_q) * AddrW'(GridCols) + AddrW'(col_q);
  assign sh_last  = asc_q ? ((row_q == RowW'(GridRows - 1)) && (col_q == ColW'(GridCols - 1)))
                          : ((row_q == '0) && (col_q == '0));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    act_d       = act_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    asc_d       = asc_q;
    row_d       = row_q;
    col_d       = col_q;
    pend_v_d    = 1'b0;
    pend_in_d   = pend_in_q;
    pend_addr_d = pend_addr_q;
    lo_new_d    = lo_new_q;
    out_v_d     = out_v_q && !m_axis_tready;
    out_occ_d   = out_occ_q;
    out_lo_d    = out_lo_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = {OccUnknown, LoW'(0)};
    ram_raddr   = AddrW'(in_idx);
    occ_req     = '{valid: 1'b0, log_odds: lo_new_q};

    if (pend_v_q) begin
      ram_we    = 1'b1;
      ram_wdata = pend_in_q ? ram_rdata : {OccUnknown, LoW'(0)};
    end

    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Cells - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          act_d = in_act;
          idx_d = AddrW'(in_idx);
          hit_d = s_axis_tdata[12];
          dx_d  = in_dx;
          dy_d  = in_dy;
          if (in_act == ActShift) begin
            if (in_dx == 0 && in_dy == 0) begin
              out_v_d   = 1'b1;
              out_occ_d = OccEmpty;
              out_lo_d  = '0;
            end else begin
              asc_d   = (in_dy > 0) || (in_dy == 0 && in_dx > 0);
              row_d   = asc_d ? '0 : RowW'(GridRows - 1);
              col_d   = asc_d ? '0 : ColW'(GridCols - 1);
              state_d = StShift;
            end
          end else if (!in_grid) begin
            out_v_d   = 1'b1;
            out_occ_d = OccUnknown;
            out_lo_d  = '0;
          end else begin
            state_d = StData;
          end
        end
      end
      StData: begin
        if (act_q == ActUpdate) begin
          priority if (sum < -lim) begin
            lo_new_d = LoW'(-lim);
          end else if (sum > lim) begin
            lo_new_d = LoW'(lim);
          end else begin
            lo_new_d = LoW'(sum);
          end
          occ_req = '{valid: 1'b1, log_odds: lo_new_d};
          state_d = StOcc;
        end else begin
          out_v_d   = 1'b1;
          out_occ_d = rd_occ;
          out_lo_d  = rd_lo;
          state_d   = StIdle;
        end
      end
      StOcc: begin
        if (occ_rsp.valid) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = {occ_rsp.occ, lo_new_q};
          out_v_d   = 1'b1;
          out_occ_d = occ_rsp.occ;
          out_lo_d  = lo_new_q;
          state_d   = StIdle;
        end
      end
      StShift: begin
        ram_raddr   = src_addr;
        pend_v_d    = 1'b1;
        pend_in_d   = src_in;
        pend_addr_d = dst_addr;
        if (asc_q) begin
          if (col_q == ColW'(GridCols - 1)) begin
            col_d = '0;
            row_d = row_q + RowW'(1);
          end else begin
            col_d = col_q + ColW'(1);
          end
        end else begin
          if (col_q == '0) begin
            col_d = ColW'(GridCols - 1);
            row_d = row_q - RowW'(1);
          end else begin
            col_d = col_q - ColW'(1);
          end
        end
        if (sh_last) begin
          state_d = StShTail;
        end
      end
      StShTail: begin
        out_v_d   = 1'b1;
        out_occ_d = OccEmpty;
        out_lo_d  = '0;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      clr_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    idx_q       <= idx_d;
    hit_q       <= hit_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    asc_q       <= asc_d;
    row_q       <= row_d;
    col_q       <= col_d;
    pend_in_q   <= pend_in_d;
    pend_addr_q <= pend_addr_d;
    lo_new_q    <= lo_new_d;
    out_occ_q   <= out_occ_d;
    out_lo_q    <= out_lo_d;
  end

  loog_ram #(
    .Width (CellW),
    .Depth (Cells)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  loog_occ u_occ (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (occ_req),
    .belief_limit_i (belief_q),
    .rsp_o          (occ_rsp)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_lo_q, out_occ_q};

`ifndef ASSERT_OFF
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !s_axis_tready)
    else $error("request taken during clearing pass");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != StIdle) || m_axis_tvalid)
    else $error("accepted request produced no work and no result");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) && !$past(state_q == StShift) |-> !ram_we)
    else $error("cell RAM written while idle");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_rsp.valid |-> (state_q == StOcc))
    else $error("occupancy result outside of update");
`endif

endmodule
